### design/assert_macros.svh
// Assertion macros shared by the attitude filter RTL.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IAGC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define IAGC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/iagc_pkg.sv
// Package for the attitude filter: payload structs, CORDIC tables and constants.
// No dependencies.
package iagc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int STEP_W = $clog2(ATAN_ENTRIES);

	localparam int CW = 34;       // CORDIC datapath width
	localparam int SQ_IN_W = 48;  // radicand width
	localparam int SQ_ROOT_W = 24;
	localparam int SQ_IT_W = $clog2(SQ_ROOT_W);

	localparam logic [15:0] BLEND_RST = 16'd64225;
	localparam logic [14:0] GRAV_RST = 15'd2511;

	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
	};

	typedef enum logic [1:0] {
		CFG_BLEND = 2'd0,
		CFG_GRAV  = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] roll_step;
		logic signed [15:0] pitch_step;
		logic signed [15:0] yaw_step;
		logic signed [15:0] yaw_drift_fix;
	} iagc_in_t;

	typedef struct packed {
		logic signed [15:0] roll_out;
		logic signed [15:0] pitch_out;
		logic signed [15:0] yaw_out;
		logic signed [15:0] tilt_roll;
		logic signed [15:0] tilt_pitch;
		logic signed [15:0] world_accel_x;
		logic signed [15:0] world_accel_y;
		logic signed [15:0] world_accel_z;
	} iagc_out_t;

	typedef struct packed {
		logic                 start;
		logic                 vec;    // 1: vectoring (atan2), 0: rotation (sin/cos)
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [15:0]          angle;
	} cordic_req_t;

	typedef struct packed {
		logic                 busy;
		logic [15:0]          angle;
		logic signed [CW-1:0] cos_v;
		logic signed [CW-1:0] sin_v;
	} cordic_rsp_t;

	function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 1/K in Q30, rounded: long division done bit by bit at elaboration
	function automatic logic [63:0] inv_gain();
		logic [63:0] k;
		logic [63:0] s;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		k = 64'd1 << 60;
		for (int i = 0; i < STEPS; i++) begin
			k = k + (k >> (2 * i));
		end
		s = isqrt_c(k);
		num = (64'd1 << 60) + (s >> 1);
		rem = 64'd0;
		q = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= s) begin
				rem = rem - s;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	localparam logic [63:0] INV_K64 = inv_gain();
	localparam logic signed [CW-1:0] INV_K = $signed(INV_K64[CW-1:0]);

endpackage

### design/iagc_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on iagc_pkg.
module iagc_isqrt
	import iagc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SQ_IN_W-1:0]   radicand,
	output logic                 busy,
	output logic [SQ_ROOT_W-1:0] root
);

	logic [SQ_IN_W-1:0] n_q, r_q, bit_q;
	logic [SQ_IT_W-1:0] it_q;
	logic               busy_q;
	logic [SQ_IN_W:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			it_q <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (it_q == SQ_IT_W'(SQ_ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
			bit_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
		end else if (busy_q) begin
			if ({1'b0, n_q} >= trial) begin
				n_q <= n_q - trial[SQ_IN_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[SQ_ROOT_W-1:0];

endmodule

### design/iagc_cordic.sv
// Shared CORDIC unit: vectoring for atan2, rotation for sine and cosine.
// Depends on iagc_pkg.
module iagc_cordic
	import iagc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [STEP_W-1:0]    it_q;
	logic                 busy_q, vec_q, flip_q, zero_q;
	logic signed [CW-1:0] dx, dy, at, zr;
	logic                 pos_dir;
	logic                 flip_in;

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = $signed({{(CW-32){1'b0}}, ATAN_TAB[it_q]});
	// x += y, y -= x, z += atan
	assign pos_dir = vec_q ? ~y_q[CW-1] : z_q[CW-1];
	assign flip_in = req.angle[15] ^ req.angle[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			it_q <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (it_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec;
			flip_q <= ~req.vec & flip_in;
			zero_q <= req.vec && (req.x == '0) && (req.y == '0);
			if (req.vec) begin
				if (!req.x[CW-1]) begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= '0;
				end else if (!req.y[CW-1]) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= CW'(64'sd1 << 30);
				end else begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= -CW'(64'sd1 << 30);
				end
			end else begin
				x_q <= INV_K;
				y_q <= '0;
				z_q <= CW'($signed({req.angle[15] ^ flip_in, req.angle[14:0], 16'h0000}));
			end
		end else if (busy_q) begin
			if (pos_dir) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign zr = z_q + CW'(32'sh8000);

	always_comb begin
		rsp.busy = busy_q;
		rsp.angle = zero_q ? 16'h0000 : zr[31:16];
		rsp.cos_v = flip_q ? -x_q : x_q;
		rsp.sin_v = flip_q ? -y_q : y_q;
	end

endmodule

### design/imu_attitude_gravity_compensation_top.sv
// Top level of the IMU attitude filter with gravity compensation.
// Depends on iagc_pkg, iagc_cordic, iagc_isqrt and assert_macros.svh.
//
// Usage:
//  in channel (in_valid/in_stall/in_data): one IMU sample per transfer with
//   body accelerations, roll/pitch/yaw increments and a yaw drift correction.
//  out channel (out_valid/out_stall/out_data): one result per sample with the
//   blended angles, accelerometer tilt angles and inertial accelerations.
//  cfg port (cfg_we/cfg_index/cfg_data): blend weight (index 0) and gravity
//   (index 1); write only while no sample is in flight.
// Sequence: a sample is processed fully before out_valid rises, and the next
//  sample is taken only after the sequencer has returned to idle.
//  The processing time is set by the shared CORDIC (five passes of CORDIC_STEPS
//  iterations plus setup), the square root that overlaps the first pass, and 29
//  products through the single shared multiplier.
//  in_stall is low only while the sequencer is idle: one sample at a time.
// Reset: angles clear to zero, registers take their default values, no
//  result is pending.
// Stall on out: the result register holds; the block may take the next sample
//  meanwhile but does not overwrite the held result until it is taken.
module imu_attitude_gravity_compensation_top
	import iagc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  iagc_in_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output iagc_out_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL   = 10'b0000000010,
		ST_DRAIN = 10'b0000000100,
		ST_ATR   = 10'b0000001000,
		ST_ATRW  = 10'b0000010000,
		ST_ATP   = 10'b0000100000,
		ST_ATPW  = 10'b0001000000,
		ST_ROT   = 10'b0010000000,
		ST_ROTW  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	// multiplier program: products issued in order, each consumed in the cycle after it is issued
	typedef enum logic [4:0] {
		OP_YY, OP_ZZ,
		OP_BR_A, OP_BR_T, OP_BP_A, OP_BP_T,
		OP_R00, OP_R01, OP_T1, OP_T2,
		OP_R10_A, OP_R10_B, OP_R11_A, OP_R11_B, OP_R12,
		OP_R20_A, OP_R20_B, OP_R21_A, OP_R21_B, OP_R22,
		OP_WX0, OP_WX1, OP_WX2, OP_WY0, OP_WY1, OP_WY2, OP_WZ0, OP_WZ1, OP_WZ2
	} op_t;

	typedef enum logic [1:0] {
		ROT_ROLL  = 2'd0,
		ROT_PITCH = 2'd1,
		ROT_YAW   = 2'd2
	} rot_t;

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	state_t   state_q;
	op_t      opc_q, end_q, cop_q;
	logic     cv_q;
	rot_t     rot_q;

	iagc_in_t in_q;
	logic [15:0] roll_q, pitch_q, yaw_q, r_int_q, p_int_q;
	logic [15:0] blend_w_q;
	logic [14:0] grav_q;
	logic [15:0] t_roll_q, t_pitch_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;
	logic signed [49:0] acc_q;
	logic [SQ_IN_W-1:0] nsq_q;

	logic signed [32:0] cx_q, sx_q, cy_q, sy_q, cz_q, sz_q, t1_q, t2_q;
	logic signed [32:0] r00_q, r01_q, r10_q, r11_q, r12_q, r20_q, r21_q, r22_q;
	logic signed [32:0] r02;
	logic signed [15:0] wx_q, wy_q, wz_q;

	iagc_out_t out_q;
	logic      out_valid_q;

	cordic_req_t c_req;
	cordic_rsp_t c_rsp;
	logic        s_start, s_busy;
	logic [SQ_ROOT_W-1:0] s_root;

	logic signed [65:0] rq_full;
	logic signed [32:0] rq;
	logic signed [49:0] psum, bsum, wsum;
	logic signed [20:0] wr;
	logic [16:0] w_comp;
	logic [31:0] sq_sum;
	logic in_take, out_take, out_load;

	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);

	assign r02 = -sy_q;
	assign w_comp = 17'h10000 - {1'b0, blend_w_q};

	iagc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (c_req),
		.rsp    (c_rsp)
	);

	iagc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_start),
		.radicand (nsq_q),
		.busy     (s_busy),
		.root     (s_root)
	);

	// CORDIC requests
	always_comb begin
		c_req = '0;
		c_req.start = (state_q == ST_ATR) || (state_q == ST_ATP) || (state_q == ST_ROT);
		c_req.vec = (state_q != ST_ROT);
		if (state_q == ST_ATR) begin
			c_req.x = CW'(in_q.accel_z) <<< 8;
			c_req.y = CW'(in_q.accel_y) <<< 8;
		end else begin
			c_req.x = $signed({{(CW-SQ_ROOT_W){1'b0}}, s_root});
			c_req.y = -(CW'(in_q.accel_x) <<< 8);
		end
		unique case (rot_q)
			ROT_ROLL:  c_req.angle = roll_q;
			ROT_PITCH: c_req.angle = pitch_q;
			ROT_YAW:   c_req.angle = yaw_q;
			default:   c_req.angle = yaw_q;
		endcase
	end
	assign s_start = (state_q == ST_ATR);

	// multiplier operand select
	always_comb begin
		unique case (opc_q)
			OP_YY:    begin mul_a = 33'(in_q.accel_y); mul_b = 33'(in_q.accel_y); end
			OP_ZZ:    begin mul_a = 33'(in_q.accel_z); mul_b = 33'(in_q.accel_z); end
			OP_BR_A:  begin
				mul_a = $signed({17'd0, blend_w_q}); mul_b = 33'($signed(r_int_q));
			end
			OP_BR_T:  begin
				mul_a = $signed({16'd0, w_comp}); mul_b = 33'($signed(t_roll_q));
			end
			OP_BP_A:  begin
				mul_a = $signed({17'd0, blend_w_q}); mul_b = 33'($signed(p_int_q));
			end
			OP_BP_T:  begin
				mul_a = $signed({16'd0, w_comp}); mul_b = 33'($signed(t_pitch_q));
			end
			OP_R00:   begin mul_a = cy_q; mul_b = cz_q; end
			OP_R01:   begin mul_a = cy_q; mul_b = sz_q; end
			OP_T1:    begin mul_a = sx_q; mul_b = sy_q; end
			OP_T2:    begin mul_a = cx_q; mul_b = sy_q; end
			OP_R10_A: begin mul_a = t1_q; mul_b = cz_q; end
			OP_R10_B: begin mul_a = cx_q; mul_b = sz_q; end
			OP_R11_A: begin mul_a = t1_q; mul_b = sz_q; end
			OP_R11_B: begin mul_a = cx_q; mul_b = cz_q; end
			OP_R12:   begin mul_a = sx_q; mul_b = cy_q; end
			OP_R20_A: begin mul_a = t2_q; mul_b = cz_q; end
			OP_R20_B: begin mul_a = sx_q; mul_b = sz_q; end
			OP_R21_A: begin mul_a = t2_q; mul_b = sz_q; end
			OP_R21_B: begin mul_a = sx_q; mul_b = cz_q; end
			OP_R22:   begin mul_a = cx_q; mul_b = cy_q; end
			OP_WX0:   begin mul_a = r00_q; mul_b = 33'(in_q.accel_x); end
			OP_WX1:   begin mul_a = r10_q; mul_b = 33'(in_q.accel_y); end
			OP_WX2:   begin mul_a = r20_q; mul_b = 33'(in_q.accel_z); end
			OP_WY0:   begin mul_a = r01_q; mul_b = 33'(in_q.accel_x); end
			OP_WY1:   begin mul_a = r11_q; mul_b = 33'(in_q.accel_y); end
			OP_WY2:   begin mul_a = r21_q; mul_b = 33'(in_q.accel_z); end
			OP_WZ0:   begin mul_a = r02;   mul_b = 33'(in_q.accel_x); end
			OP_WZ1:   begin mul_a = r12_q; mul_b = 33'(in_q.accel_y); end
			OP_WZ2:   begin mul_a = r22_q; mul_b = 33'(in_q.accel_z); end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// product post-processing
	assign rq_full = prod_q + 66'sd536870912;
	assign rq = rq_full[62:30];
	assign psum = acc_q + prod_q[49:0];
	assign bsum = psum + 50'sd32768;
	assign wsum = psum + 50'sd536870912;
	// floor of the rounded sum, kept signed
	assign wr = 21'($signed(wsum[49:30]));
	assign sq_sum = acc_q[31:0] + prod_q[31:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			opc_q <= OP_YY;
			end_q <= OP_ZZ;
			cv_q <= 1'b0;
			rot_q <= ROT_ROLL;
			out_valid_q <= 1'b0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			blend_w_q <= BLEND_RST;
			grav_q <= GRAV_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLEND: blend_w_q <= cfg_data;
					CFG_GRAV:  grav_q <= cfg_data[14:0];
					default:   ;
				endcase
			end
			cv_q <= (state_q == ST_MUL);
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						yaw_q <= yaw_q + in_data.yaw_step + in_data.yaw_drift_fix;
						opc_q <= OP_YY;
						end_q <= OP_ZZ;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					opc_q <= op_t'(opc_q + 5'd1);
					if (opc_q == end_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					priority if (end_q == OP_ZZ) begin
						state_q <= ST_ATR;
					end else if (end_q == OP_BP_T) begin
						rot_q <= ROT_ROLL;
						state_q <= ST_ROT;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_ATR:  state_q <= ST_ATRW;
				ST_ATRW: begin
					if (!c_rsp.busy && !s_busy) begin
						state_q <= ST_ATP;
					end
				end
				ST_ATP:  state_q <= ST_ATPW;
				ST_ATPW: begin
					if (!c_rsp.busy) begin
						opc_q <= OP_BR_A;
						end_q <= OP_BP_T;
						state_q <= ST_MUL;
					end
				end
				ST_ROT:  state_q <= ST_ROTW;
				ST_ROTW: begin
					if (!c_rsp.busy) begin
						if (rot_q == ROT_YAW) begin
							opc_q <= OP_R00;
							end_q <= OP_WZ2;
							state_q <= ST_MUL;
						end else begin
							rot_q <= rot_t'(rot_q + 2'd1);
							state_q <= ST_ROT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// angle state updates from the blend products
			if (cv_q && (cop_q == OP_BR_T)) begin
				roll_q <= bsum[31:16];
			end
			if (cv_q && (cop_q == OP_BP_T)) begin
				pitch_q <= bsum[31:16];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_q <= in_data;
			r_int_q <= roll_q + in_data.roll_step;
			p_int_q <= pitch_q + in_data.pitch_step;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			cop_q <= opc_q;
		end
		if (state_q == ST_ATRW && !c_rsp.busy && !s_busy) begin
			t_roll_q <= c_rsp.angle;
		end
		if (state_q == ST_ATPW && !c_rsp.busy) begin
			t_pitch_q <= c_rsp.angle;
		end
		if (state_q == ST_ROTW && !c_rsp.busy) begin
			unique case (rot_q)
				ROT_ROLL:  begin cx_q <= c_rsp.cos_v[32:0]; sx_q <= c_rsp.sin_v[32:0]; end
				ROT_PITCH: begin cy_q <= c_rsp.cos_v[32:0]; sy_q <= c_rsp.sin_v[32:0]; end
				ROT_YAW:   begin cz_q <= c_rsp.cos_v[32:0]; sz_q <= c_rsp.sin_v[32:0]; end
				default:   ;
			endcase
		end
		if (cv_q) begin
			unique case (cop_q)
				OP_YY:    acc_q <= prod_q[49:0];
				OP_ZZ:    nsq_q <= {sq_sum, 16'h0000};
				OP_BR_A:  acc_q <= prod_q[49:0];
				OP_BR_T:  ;
				OP_BP_A:  acc_q <= prod_q[49:0];
				OP_BP_T:  ;
				OP_R00:   r00_q <= rq;
				OP_R01:   r01_q <= rq;
				OP_T1:    t1_q <= rq;
				OP_T2:    t2_q <= rq;
				OP_R10_A: acc_q <= 50'(rq);
				OP_R10_B: r10_q <= acc_q[32:0] - rq;
				OP_R11_A: acc_q <= 50'(rq);
				OP_R11_B: r11_q <= acc_q[32:0] + rq;
				OP_R12:   r12_q <= rq;
				OP_R20_A: acc_q <= 50'(rq);
				OP_R20_B: r20_q <= acc_q[32:0] + rq;
				OP_R21_A: acc_q <= 50'(rq);
				OP_R21_B: r21_q <= acc_q[32:0] - rq;
				OP_R22:   r22_q <= rq;
				OP_WX0, OP_WY0, OP_WZ0: acc_q <= prod_q[49:0];
				OP_WX1, OP_WY1, OP_WZ1: acc_q <= psum;
				OP_WX2:   wx_q <= sat16(wr);
				OP_WY2:   wy_q <= sat16(wr);
				OP_WZ2:   wz_q <= sat16(wr - $signed({6'd0, grav_q}));
				default:  ;
			endcase
		end
		if (out_load) begin
			out_q.roll_out <= roll_q;
			out_q.pitch_out <= pitch_q;
			out_q.yaw_out <= yaw_q;
			out_q.tilt_roll <= t_roll_q;
			out_q.tilt_pitch <= t_pitch_q;
			out_q.world_accel_x <= wx_q;
			out_q.world_accel_y <= wy_q;
			out_q.world_accel_z <= wz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`include "assert_macros.svh"

	// a new sample always starts with the radicand products
	`IAGC_ASSERT_NXT(a_take_starts_mul, in_take, (state_q == ST_MUL) && (opc_q == OP_YY))
	// a held result is never overwritten by the next sample
	`IAGC_ASSERT_NXT(a_no_overwrite, (state_q == ST_OUT) && out_valid_q && out_stall,
		state_q == ST_OUT)
	// the shared CORDIC is started only when it has finished its last job
	`IAGC_ASSERT_IMP(a_cordic_free, c_req.start, !c_rsp.busy)

endmodule
